### hdl/sppu_pkg.sv
// Shared types, constants and the arctangent table of the scan perimeter unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sppu_pkg;

  localparam int DEF_MAX_READINGS = 512;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_RANGE_BITS   = 16;

  localparam int RNG_W     = 16;   // range field
  localparam int CNT_W     = 10;   // count registers
  localparam int ANG_W     = 16;   // start angle registers
  localparam int IDX_W     = 11;   // reading index, total of both scans
  localparam int STEP_W    = 26;   // Q24 angular step
  localparam int TH_W      = 38;   // unreduced Q24 angle
  localparam int ZW        = 28;   // CORDIC angle accumulator
  localparam int OUT_W     = 32;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int RED_STEPS = 11;   // quotient bits of the 2*pi reduction
  localparam int ITER_W    = 5;    // CORDIC step counter

  localparam longint PI_Q24      = 52707179;
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint TWO_PI_Q24  = 105414357;
  localparam longint GAIN_INV_Q16 = 39797;
  localparam int     REAR_ANGLE_RESET = 25736;

  typedef enum logic [1:0] {
    REG_FRONT_COUNT = 2'd0,
    REG_REAR_COUNT  = 2'd1,
    REG_FRONT_ANGLE = 2'd2,
    REG_REAR_ANGLE  = 2'd3
  } sppu_reg_t;

  typedef struct packed {
    logic [RNG_W-1:0]       range;
    logic signed [TH_W-1:0] theta;
    logic                   first;
    logic                   last;
  } sppu_item_t;

  function automatic logic signed [ZW-1:0] sppu_atan(input logic [ITER_W-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/sppu_div.sv
// Serial restoring divider that works out the angular step pi/(count-1).
// Depends on sppu_pkg.
`timescale 1ns / 1ps

module sppu_div
  import sppu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [STEP_W-1:0] num,
  input  logic [CNT_W-1:0]  den,
  output logic              busy,
  output logic [STEP_W-1:0] quo
);

  logic [STEP_W-1:0] num_r, num_nxt;
  logic [STEP_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, num_r[STEP_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[STEP_W-2:0], 1'b0};
      quo_nxt = {quo_r[STEP_W-2:0], ge};
      rem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ITER_W'(STEP_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      quo_r  <= quo_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

### hdl/sppu_front.sv
// Front end: register port, step dividers, reading index and angle of each reading.
// Depends on sppu_pkg and sppu_div.
`timescale 1ns / 1ps

module sppu_front
  import sppu_pkg::*;
#(
  parameter int MAX_READINGS = DEF_MAX_READINGS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RNG_W-1:0]  in_range_mm,
  output logic              q_valid,
  input  logic              q_ready,
  output sppu_item_t        q_item
);

  logic [CNT_W-1:0] fcount_r, rcount_r;
  logic [ANG_W-1:0] fangle_r, rangle_r;
  logic             fzero_r, rzero_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [RNG_W-1:0]  s1_range_r;
  logic signed [TH_W-1:0] s1_base_r;
  logic [IDX_W-1:0]  s1_rel_r;
  logic [STEP_W-1:0] s1_step_r;
  logic              s1_first_r, s1_last_r;

  logic              wr_en;
  sppu_reg_t         wr_reg;
  logic [CNT_W-1:0]  wr_eff;
  logic              fstart, rstart;
  logic              fbusy, rbusy;
  logic [STEP_W-1:0] fquo, rquo;
  logic [STEP_W-1:0] div_num;
  logic [CNT_W-1:0]  div_den;

  logic [CNT_W-1:0]  fc, rc;
  logic [IDX_W-1:0]  total;
  logic              is_front;
  logic              accept, load, push;
  logic [IDX_W:0]    idx_inc;
  logic              last;
  logic signed [ANG_W-1:0] start_ang;
  logic [STEP_W-1:0] step_sel;
  logic [TH_W-1:0]   prod;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    return (int'(c) > MAX_READINGS) ? CNT_W'(MAX_READINGS) : c;
  endfunction

  // Register writes; a count write of two or more restarts its step divider
  assign wr_en   = psel & penable & pwrite;
  assign wr_reg  = sppu_reg_t'(paddr[3:2]);
  assign wr_eff  = eff_count(pwdata[CNT_W-1:0]);
  assign div_den = wr_eff - 1'b1;
  assign div_num = STEP_W'(PI_Q24) + STEP_W'(div_den >> 1);
  assign fstart  = wr_en && (wr_reg == REG_FRONT_COUNT) && (wr_eff >= CNT_W'(2));
  assign rstart  = wr_en && (wr_reg == REG_REAR_COUNT) && (wr_eff >= CNT_W'(2));

  sppu_div u_fdiv (
    .clk(clk), .rst_n(rst_n), .start(fstart), .num(div_num), .den(div_den),
    .busy(fbusy), .quo(fquo)
  );

  sppu_div u_rdiv (
    .clk(clk), .rst_n(rst_n), .start(rstart), .num(div_num), .den(div_den),
    .busy(rbusy), .quo(rquo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r <= '0;
      rcount_r <= '0;
      fangle_r <= '0;
      rangle_r <= ANG_W'(REAR_ANGLE_RESET);
      fzero_r  <= 1'b1;
      rzero_r  <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_reg)
        REG_FRONT_COUNT: begin
          fcount_r <= pwdata[CNT_W-1:0];
          fzero_r  <= wr_eff < CNT_W'(2);
        end
        REG_REAR_COUNT: begin
          rcount_r <= pwdata[CNT_W-1:0];
          rzero_r  <= wr_eff < CNT_W'(2);
        end
        REG_FRONT_ANGLE: fangle_r <= pwdata[ANG_W-1:0];
        REG_REAR_ANGLE:  rangle_r <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sppu_reg_t'(paddr[3:2]))
      REG_FRONT_COUNT: prdata = APB_DW'(fcount_r);
      REG_REAR_COUNT:  prdata = APB_DW'(rcount_r);
      REG_FRONT_ANGLE: prdata = APB_DW'(fangle_r);
      REG_REAR_ANGLE:  prdata = APB_DW'(rangle_r);
      default:         prdata = '0;
    endcase
  end

  // Classify the reading: which scan, where in it, first or closing
  assign fc       = eff_count(fcount_r);
  assign rc       = eff_count(rcount_r);
  assign total    = IDX_W'(fc) + IDX_W'(rc);
  assign is_front = idx_r < IDX_W'(fc);
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign last     = idx_inc >= {1'b0, total};
  assign start_ang = is_front ? fangle_r : rangle_r;
  assign step_sel  = is_front ? (fzero_r ? '0 : fquo) : (rzero_r ? '0 : rquo);

  assign push     = s1_valid_r && q_ready;
  assign in_stall = fbusy || rbusy || (s1_valid_r && !q_ready);
  assign accept   = in_valid && !in_stall;
  assign load     = accept && (total != '0);

  always_comb begin
    idx_nxt      = idx_r;
    s1_valid_nxt = s1_valid_r;
    if (push) s1_valid_nxt = 1'b0;
    if (load) begin
      s1_valid_nxt = 1'b1;
      idx_nxt      = last ? '0 : idx_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    if (load) begin
      s1_range_r <= in_range_mm;
      s1_base_r  <= (TH_W'(start_ang) <<< 11) - TH_W'(HALF_PI_Q24);
      s1_rel_r   <= is_front ? idx_r : idx_r - IDX_W'(fc);
      s1_step_r  <= step_sel;
      s1_first_r <= idx_r == '0;
      s1_last_r  <= last;
    end
  end

  assign prod = TH_W'(s1_rel_r) * TH_W'(s1_step_r);

  assign q_valid       = s1_valid_r;
  assign q_item.range  = s1_range_r;
  assign q_item.theta  = s1_base_r + $signed(prod);
  assign q_item.first  = s1_first_r;
  assign q_item.last   = s1_last_r;

endmodule

### hdl/sppu_queue.sv
// Short queue of classified readings between the front end and the back end.
// Depends on sppu_pkg.
`timescale 1ns / 1ps

module sppu_queue
  import sppu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  sppu_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output sppu_item_t pop_item
);

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  sppu_item_t      mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_r, rd_r;
  logic [QA_W:0]   cnt_r;
  logic            do_push, do_pop;

  assign push_ready = cnt_r != (QA_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QA_W+1)'(do_push) - (QA_W+1)'(do_pop);
    end
    if (do_push) mem[wr_r] <= push_item;
  end

endmodule

### hdl/sppu_back.sv
// Back end: angle reduction, rotation and vectoring CORDIC, running sum and result.
// Depends on sppu_pkg.
`timescale 1ns / 1ps

module sppu_back
  import sppu_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int RANGE_BITS   = DEF_RANGE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  sppu_item_t       q_item,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_perimeter_mm
);

  localparam int RW = (RANGE_BITS < RNG_W) ? RANGE_BITS : RNG_W;
  localparam int PW = RW + 10;       // Q8 point coordinate
  localparam int VW = PW + 3;        // vectoring datapath
  localparam int SW = VW + 12;       // running sum
  localparam int XP_W = RW + 17;
  localparam int EP_W = VW + 17;
  localparam logic [RNG_W-1:0] RMASK = RNG_W'((64'd1 << RW) - 64'd1);
  localparam logic signed [TH_W-1:0] PI_T     = TH_W'(PI_Q24);
  localparam logic signed [TH_W-1:0] HALF_T   = TH_W'(HALF_PI_Q24);
  localparam logic signed [TH_W-1:0] TWO_PI_T = TH_W'(TWO_PI_Q24);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PREP   = 10'b0000000010,
    S_REDUCE = 10'b0000000100,
    S_FOLD   = 10'b0000001000,
    S_ROT    = 10'b0000010000,
    S_PLACE  = 10'b0000100000,
    S_VEC    = 10'b0001000000,
    S_EMUL   = 10'b0010000000,
    S_ACC    = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [TH_W-1:0] th_r, w_r;
  logic                   gt_r;
  logic [3:0]             k_r;
  logic [RNG_W-1:0]       rng_r;
  logic                   first_r, last_r, cls_r, flip_r;
  logic signed [PW-1:0]   x0_r, x_r, y_r;
  logic signed [ZW-1:0]   z_r;
  logic [ITER_W-1:0]      i_r;
  logic signed [VW-1:0]   vx_r, vy_r;
  logic [VW-1:0]          edge_r;
  logic signed [PW-1:0]   fx_r, fy_r, px_r, py_r;
  logic [SW-1:0]          sum_r;
  logic [OUT_W-1:0]       out_r;
  logic                   out_valid_r;

  logic signed [TH_W-1:0] tfix, cmp2pi, zr;
  logic [XP_W-1:0]        xprod;
  logic [EP_W-1:0]        eprod;
  logic signed [PW-1:0]   p_x, p_y;
  logic signed [PW-1:0]   a_x, a_y, b_x, b_y;
  logic signed [VW-1:0]   dxs, vx0, vy0;
  logic [SW:0]            mm;
  logic                   out_free;
  logic                   last_iter;

  assign q_ready  = state_r == S_IDLE;
  assign out_free = !out_valid_r || !out_stall;
  assign last_iter = i_r == ITER_W'(CORDIC_STEPS - 1);

  assign tfix   = (th_r < -PI_T) ? th_r + TWO_PI_T : th_r;
  assign cmp2pi = TWO_PI_T <<< k_r;
  assign zr     = gt_r ? ((w_r == '0) ? PI_T : w_r - PI_T) : th_r;
  assign xprod  = XP_W'(rng_r & RMASK) * XP_W'(GAIN_INV_Q16) + XP_W'(128);
  assign eprod  = EP_W'($unsigned(vx_r)) * EP_W'(GAIN_INV_Q16) + EP_W'(32768);
  assign p_x    = flip_r ? -x_r : x_r;
  assign p_y    = flip_r ? -y_r : y_r;
  assign mm     = ({1'b0, sum_r} + (SW+1)'(128)) >> 8;

  // Edge operands: new edge when a point is placed, closing edge after accumulation
  always_comb begin
    if (state_r == S_PLACE) begin
      a_x = first_r ? p_x : px_r;
      a_y = first_r ? p_y : py_r;
      b_x = p_x;
      b_y = p_y;
    end else begin
      a_x = px_r;
      a_y = py_r;
      b_x = fx_r;
      b_y = fy_r;
    end
  end
  assign dxs = VW'(b_x) - VW'(a_x);
  assign vx0 = (dxs < 0) ? -dxs : dxs;
  assign vy0 = VW'(b_y) - VW'(a_y);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (q_valid) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_REDUCE;
      S_REDUCE: if (k_r == '0) state_nxt = S_FOLD;
      S_FOLD:   state_nxt = S_ROT;
      S_ROT:    if (last_iter) state_nxt = S_PLACE;
      S_PLACE:  state_nxt = (!first_r || last_r) ? S_VEC : S_IDLE;
      S_VEC:    if (last_iter) state_nxt = S_EMUL;
      S_EMUL:   state_nxt = S_ACC;
      S_ACC: begin
        priority if (cls_r)  state_nxt = S_FIN;
        else if (last_r)     state_nxt = S_VEC;
        else                 state_nxt = S_IDLE;
      end
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)             out_valid_r <= 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          th_r    <= q_item.theta;
          rng_r   <= q_item.range;
          first_r <= q_item.first;
          last_r  <= q_item.last;
        end
      end
      S_PREP: begin
        th_r <= tfix;
        gt_r <= tfix > PI_T;
        w_r  <= tfix + PI_T;
        k_r  <= 4'(RED_STEPS - 1);
        x0_r <= PW'(xprod >> 8);
      end
      S_REDUCE: begin
        if (w_r >= cmp2pi) w_r <= w_r - cmp2pi;
        k_r <= k_r - 1'b1;
      end
      S_FOLD: begin
        priority if (zr > HALF_T) begin
          z_r    <= ZW'(zr - PI_T);
          flip_r <= 1'b1;
        end else if (zr < -HALF_T) begin
          z_r    <= ZW'(zr + PI_T);
          flip_r <= 1'b1;
        end else begin
          z_r    <= ZW'(zr);
          flip_r <= 1'b0;
        end
        x_r <= x0_r;
        y_r <= '0;
        i_r <= '0;
      end
      S_ROT: begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> i_r);
          y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - sppu_atan(i_r);
        end else begin
          x_r <= x_r + (y_r >>> i_r);
          y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + sppu_atan(i_r);
        end
        i_r <= i_r + 1'b1;
      end
      S_PLACE: begin
        px_r <= p_x;
        py_r <= p_y;
        if (first_r) begin
          fx_r  <= p_x;
          fy_r  <= p_y;
          sum_r <= '0;
        end
        cls_r <= first_r;
        vx_r  <= vx0;
        vy_r  <= vy0;
        i_r   <= '0;
      end
      S_VEC: begin
        if (vy_r > 0) begin
          vx_r <= vx_r + (vy_r >>> i_r);
          vy_r <= vy_r - (vx_r >>> i_r);
        end else begin
          vx_r <= vx_r - (vy_r >>> i_r);
          vy_r <= vy_r + (vx_r >>> i_r);
        end
        i_r <= i_r + 1'b1;
      end
      S_EMUL: edge_r <= eprod[VW+15:16];
      S_ACC: begin
        sum_r <= sum_r + SW'(edge_r);
        // Set up the closing edge back to the first point
        if (!cls_r && last_r) begin
          cls_r <= 1'b1;
          vx_r  <= vx0;
          vy_r  <= vy0;
          i_r   <= '0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_r <= ((mm >> OUT_W) != '0) ? '1 : mm[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_perimeter_mm = out_r;

endmodule

### hdl/scan_polygon_perimeter_unit.sv
// Top level of the scan perimeter unit: front end, request queue and back end.
// Depends on sppu_pkg, sppu_front, sppu_queue and sppu_back.
`timescale 1ns / 1ps
//
//  channel  | handshake               | payload            | role
//  ---------+-------------------------+--------------------+--------------------------
//  in       | in_valid / in_stall     | in_range_mm[15:0]  | one range reading per request
//  out      | out_valid / out_stall   | out_perimeter_mm   | perimeter once a polygon closes
//  config   | psel penable pwrite     | paddr pwdata prdata| counts and start angles
//
//  In the back end a reading is popped, prepared, reduced modulo 2*pi, folded and turned
//  by the 16 rotation CORDIC steps; then the point is placed and its edge is vectored by
//  16 vectoring steps, scaled and added. The first reading of a polygon, unless it is
//  also the last, skips vectoring; the closing reading adds a second vectoring pass for
//  the closing edge and an output step. The back end takes a new reading only when idle.
//  A count write of two or more runs a step division; in_stall stays high until it ends.
//  Reset is synchronous and active low; no clearing pass is needed.
//  The queue holds two requests, so the front keeps accepting until it fills while the
//  back works or while a finished result waits on out_stall.

module scan_polygon_perimeter_unit
  import sppu_pkg::*;
#(
  parameter int MAX_READINGS = DEF_MAX_READINGS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int RANGE_BITS   = DEF_RANGE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RNG_W-1:0]  in_range_mm,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_perimeter_mm
);

  logic       f_valid, f_ready;
  sppu_item_t f_item;
  logic       b_valid, b_ready;
  sppu_item_t b_item;

  // Zero wait states on the register port
  assign pready = 1'b1;

  // Classify each reading and form its angle
  sppu_front #(
    .MAX_READINGS(MAX_READINGS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_range_mm(in_range_mm),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  // Decouple the two halves
  sppu_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
  );

  // Convert to points, measure edges, hold the result
  sppu_back #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .RANGE_BITS(RANGE_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_perimeter_mm(out_perimeter_mm)
  );

endmodule
